### rtl/mfmenc_pkg.sv
// shared types, constants and the mfm cell encoder for the block data to flux cell converter
package mfmenc_pkg;

  // budget width of the cell counter, capped by the 24-bit budget field
  localparam int BUDGET_BITS = 24;
  localparam int CELLS_W     = (BUDGET_BITS < 24) ? BUDGET_BITS : 24;
  // width of the cells needed by one element: parameter times 16, or times 8 for raw
  localparam int NEED_W      = 36;

  // op queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // element codes
  localparam logic [4:0] EL_END  = 5'd0;
  localparam logic [4:0] EL_RAW  = 5'd1;
  localparam logic [4:0] EL_DATA = 5'd2;
  localparam logic [4:0] EL_GAP  = 5'd3;
  localparam logic [4:0] EL_WEAK = 5'd5;

  // result kinds
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_WEAK = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [4:0] RAW_CELLS = 5'd8;
  localparam logic [4:0] MFM_CELLS = 5'd16;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PARAM,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    OP_RAW,
    OP_MFM,
    OP_WEAK,
    OP_OK,
    OP_ERR
  } op_code_t;

  typedef struct packed {
    logic        command;
    logic [23:0] cell_budget;
    logic [7:0]  data_byte;
    logic        final_byte;
  } desc_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cell_bits;
    logic [4:0]  cell_count;
    logic [23:0] weak_cells;
  } flux_item_t;

  // work for the back end: one op per result item
  typedef struct packed {
    op_code_t           code;
    logic               fail;
    logic [7:0]         data;
    logic [CELLS_W-1:0] weak_len;
  } op_t;

  // mfm: clock cell set only when previous and current data bits are both clear
  function automatic logic [15:0] mfm_encode(input logic [7:0] b, input logic ctx);
    logic [15:0] w;
    logic        prev;
    w    = '0;
    prev = ctx;
    for (int i = 7; i >= 0; i--) begin
      w[2*i+1] = ~(prev | b[i]);
      w[2*i]   = b[i];
      prev     = b[i];
    end
    return w;
  endfunction

endpackage

### rtl/mfmenc_front.sv
// front end: descriptor parser, budget accounting and op generation
module mfmenc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 desc_valid,
  input  logic                 desc_stall,
  input  mfmenc_pkg::desc_item_t desc_data,
  output logic                 push,
  output mfmenc_pkg::op_t      push_op
);
  import mfmenc_pkg::*;

  phase_t             phase, phase_next;
  logic [4:0]         element_code, element_code_next;
  logic [2:0]         param_bytes_left, param_bytes_left_next;
  logic [31:0]        param_value, param_value_next;
  logic [31:0]        payload_bytes_left, payload_bytes_left_next;
  logic [CELLS_W-1:0] cells_left, cells_left_next;

  logic               accept;
  logic               finish;
  logic [4:0]         code_f;
  logic [31:0]        param_f;
  logic [31:0]        param_shift;
  logic [NEED_W-1:0]  need;
  logic [NEED_W:0]    diff;
  logic               over;

  assign accept = desc_valid && !desc_stall;

  // parameter with the incoming byte shifted in
  assign param_shift = {param_value[23:0], desc_data.data_byte};

  // element being finished: from a header alone or the last parameter byte
  always_comb begin
    if (phase == PH_HEADER) begin
      code_f  = desc_data.data_byte[4:0];
      param_f = '0;
    end else begin
      code_f  = element_code;
      param_f = param_shift;
    end
  end

  // budget check without wrap
  assign need = (code_f == EL_RAW) ? {1'b0, param_f, 3'b000} : {param_f, 4'b0000};
  assign diff = {{(NEED_W + 1 - CELLS_W){1'b0}}, cells_left} - {1'b0, need};
  assign over = diff[NEED_W];

  // next state and op
  always_comb begin
    phase_next              = phase;
    element_code_next       = element_code;
    param_bytes_left_next   = param_bytes_left;
    param_value_next        = param_value;
    payload_bytes_left_next = payload_bytes_left;
    cells_left_next         = cells_left;
    finish                  = 1'b0;
    push                    = 1'b0;
    push_op                 = '{code: OP_ERR, fail: 1'b0, data: desc_data.data_byte,
                                weak_len: '0};

    if (accept) begin
      if (desc_data.command == CMD_START) begin
        cells_left_next         = desc_data.cell_budget[CELLS_W-1:0];
        phase_next              = PH_HEADER;
        element_code_next       = EL_END;
        param_bytes_left_next   = '0;
        param_value_next        = '0;
        payload_bytes_left_next = '0;
      end else if (phase != PH_IDLE) begin
        unique case (phase)
          PH_HEADER: begin
            element_code_next     = desc_data.data_byte[4:0];
            param_bytes_left_next = desc_data.data_byte[7:5];
            param_value_next      = '0;
            if (code_f != EL_END && code_f != EL_RAW && code_f != EL_DATA &&
                code_f != EL_GAP && code_f != EL_WEAK) begin
              phase_next   = PH_IDLE;
              push         = 1'b1;
              push_op.code = OP_ERR;
            end else if (desc_data.data_byte[7:5] == 3'd0) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_PARAM;
            end
          end
          PH_PARAM: begin
            param_value_next      = param_shift;
            param_bytes_left_next = param_bytes_left - 3'd1;
            if (param_bytes_left == 3'd1) begin
              finish = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            push                    = 1'b1;
            push_op.code            = (element_code == EL_RAW) ? OP_RAW : OP_MFM;
            payload_bytes_left_next = payload_bytes_left - 32'd1;
            if (payload_bytes_left == 32'd1) begin
              phase_next = PH_HEADER;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // element complete: act on code and parameter
        if (finish) begin
          if (code_f == EL_END) begin
            phase_next   = PH_IDLE;
            push         = 1'b1;
            push_op.code = (cells_left == '0) ? OP_OK : OP_ERR;
          end else if (over) begin
            phase_next   = PH_IDLE;
            push         = 1'b1;
            push_op.code = OP_ERR;
          end else if (code_f == EL_WEAK) begin
            cells_left_next  = diff[CELLS_W-1:0];
            phase_next       = PH_HEADER;
            push             = 1'b1;
            push_op.code     = OP_WEAK;
            push_op.weak_len = need[CELLS_W-1:0];
          end else begin
            cells_left_next         = diff[CELLS_W-1:0];
            payload_bytes_left_next = param_f;
            phase_next              = (param_f != '0) ? PH_PAYLOAD : PH_HEADER;
          end
        end

        // stream ended with the block still open
        if (desc_data.final_byte && phase_next != PH_IDLE) begin
          phase_next   = PH_IDLE;
          push_op.fail = 1'b1;
          if (!push) begin
            push_op.code = OP_ERR;
          end
          push = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      element_code       <= '0;
      param_bytes_left   <= '0;
      param_value        <= '0;
      payload_bytes_left <= '0;
      cells_left         <= '0;
    end else begin
      phase              <= phase_next;
      element_code       <= element_code_next;
      param_bytes_left   <= param_bytes_left_next;
      param_value        <= param_value_next;
      payload_bytes_left <= payload_bytes_left_next;
      cells_left         <= cells_left_next;
    end
  end

  // a failed op always closes the block
  a_fail_closes: assert property (@(posedge clk) disable iff (rst)
    push && push_op.fail |=> phase == PH_IDLE)
    else $error("fail op left block open");

  // payload bytes only emit words
  a_payload_word: assert property (@(posedge clk) disable iff (rst)
    accept && desc_data.command == CMD_BYTE && phase == PH_PAYLOAD |->
      push && (push_op.code == OP_RAW || push_op.code == OP_MFM))
    else $error("payload byte without word op");

endmodule

### rtl/mfmenc_queue.sv
// short op queue between the parser and the cell generator
module mfmenc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mfmenc_pkg::op_t push_op,
  output logic            full,
  input  logic            pop,
  output mfmenc_pkg::op_t head,
  output logic            empty
);
  import mfmenc_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QUEUE_DEPTH[QPTR_W:0]);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("op pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_DEPTH[QPTR_W:0])
    else $error("queue count out of range");

endmodule

### rtl/mfmenc_back.sv
// back end: turns ops into cell words and status items, holds the mfm context
module mfmenc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mfmenc_pkg::op_t        head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   flux_valid,
  input  logic                   flux_stall,
  output mfmenc_pkg::flux_item_t flux_data
);
  import mfmenc_pkg::*;

  logic       mfm_context, mfm_context_next;
  flux_item_t result;

  // take the next op when the output register is free or being taken
  assign pop = !empty && (!flux_valid || !flux_stall);

  // result and context update for the head op
  always_comb begin
    result           = '{kind: KIND_ERR, cell_bits: '0, cell_count: '0, weak_cells: '0};
    mfm_context_next = mfm_context;
    unique case (head.code)
      OP_RAW: begin
        result.kind       = KIND_WORD;
        result.cell_bits  = {head.data, 8'h00};
        result.cell_count = RAW_CELLS;
        mfm_context_next  = head.data[0];
      end
      OP_MFM: begin
        result.kind       = KIND_WORD;
        result.cell_bits  = mfm_encode(head.data, mfm_context);
        result.cell_count = MFM_CELLS;
        mfm_context_next  = head.data[0];
      end
      OP_WEAK: begin
        result.kind       = KIND_WEAK;
        result.weak_cells = {{(24 - CELLS_W){1'b0}}, head.weak_len};
        mfm_context_next  = 1'b0;
      end
      OP_OK: begin
        result.kind = KIND_OK;
      end
      OP_ERR: begin
        result.kind = KIND_ERR;
      end
      default: begin
        result.kind = KIND_ERR;
      end
    endcase
    // stream end overrides the result, context still advances
    if (head.fail) begin
      result = '{kind: KIND_ERR, cell_bits: '0, cell_count: '0, weak_cells: '0};
    end
  end

  // context and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mfm_context <= 1'b0;
      flux_valid  <= 1'b0;
    end else begin
      if (pop) begin
        mfm_context <= mfm_context_next;
        flux_valid  <= 1'b1;
      end else if (!flux_stall) begin
        flux_valid  <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      flux_data <= result;
    end
  end

  a_count_kind: assert property (@(posedge clk) disable iff (rst)
    flux_valid |-> (flux_data.kind == KIND_WORD) == (flux_data.cell_count != 5'd0))
    else $error("cell count does not match kind");

  a_weak_clears: assert property (@(posedge clk) disable iff (rst)
    pop && head.code == OP_WEAK |=> !mfm_context)
    else $error("weak run left mfm context set");

endmodule

### rtl/block_data_stream_to_mfm_cells.sv
// top level: block data descriptor stream to raw, mfm and weak flux cells
//
//   channel | dir | handshake               | payload
//   desc    | in  | desc_valid / desc_stall | desc_data (desc_item_t)
//   flux    | out | flux_valid / flux_stall | flux_data (flux_item_t)
//
// one item per cycle in while desc_stall is low, one result per cycle out while
// flux_stall is low and the queue holds an op; each item gives at most one result
// a result is written to the op queue, then to the output register when that is free
// rst is synchronous and clears the parser, the op queue and the mfm context
// desc_stall rises only when the four-entry op queue is full
// flux_stall holds the output register; the queue absorbs items meanwhile
module block_data_stream_to_mfm_cells (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   desc_valid,
  output logic                   desc_stall,
  input  mfmenc_pkg::desc_item_t desc_data,
  output logic                   flux_valid,
  input  logic                   flux_stall,
  output mfmenc_pkg::flux_item_t flux_data
);
  import mfmenc_pkg::*;

  logic q_push;
  op_t  q_push_op;
  logic q_full;
  logic q_pop;
  op_t  q_head;
  logic q_empty;

  assign desc_stall = q_full;

  // parser and budget
  mfmenc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc_data  (desc_data),
    .push       (q_push),
    .push_op    (q_push_op)
  );

  // op queue
  mfmenc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  // cell generator
  mfmenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .flux_valid (flux_valid),
    .flux_stall (flux_stall),
    .flux_data  (flux_data)
  );

endmodule

### tb/flux_cell_checker.sv
// checker for the mfm cell converter: watches both channels, predicts flux items and compares
`timescale 1ns / 1ps

module flux_cell_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   desc_valid,
  input  logic                   desc_stall,
  input  mfmenc_pkg::desc_item_t desc_data,
  input  logic                   flux_valid,
  input  logic                   flux_stall,
  input  mfmenc_pkg::flux_item_t flux_data,
  output int                     fail_count,
  output int                     pending
);
  import mfmenc_pkg::*;

  // parser state of the predicted block
  phase_t      ph;
  logic [4:0]  el_code;
  logic [2:0]  prm_left;
  logic [31:0] prm_val;
  logic [31:0] pay_left;
  logic [23:0] cells_left;
  logic        mfm_ctx;

  flux_item_t  flux_expected[$];
  int          n_flux;

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("flux item %0d: %s", n_flux, what);
    end
    fail_count++;
  endtask

  // element fully described: act on its code and parameter
  task automatic close_element(output bit got, output logic [1:0] k, output logic [23:0] wk);
    logic [35:0] need;
    got  = 1'b0;
    k    = KIND_WORD;
    wk   = '0;
    need = {4'd0, prm_val} << 4;
    case (el_code)
      EL_END: begin
        ph  = PH_IDLE;
        got = 1'b1;
        k   = (cells_left == 0) ? KIND_OK : KIND_ERR;
      end
      EL_RAW, EL_DATA, EL_GAP: begin
        if (el_code == EL_RAW) begin
          need = {4'd0, prm_val} << 3;
        end
        // budget check on the full width, no wrap
        if (need > {12'd0, cells_left}) begin
          ph  = PH_IDLE;
          got = 1'b1;
          k   = KIND_ERR;
        end else begin
          cells_left = cells_left - need[23:0];
          pay_left   = prm_val;
          ph         = (prm_val != 0) ? PH_PAYLOAD : PH_HEADER;
        end
      end
      EL_WEAK: begin
        got = 1'b1;
        if (need > {12'd0, cells_left}) begin
          ph = PH_IDLE;
          k  = KIND_ERR;
        end else begin
          cells_left = cells_left - need[23:0];
          mfm_ctx    = 1'b0;
          wk         = need[23:0];
          k          = KIND_WEAK;
          ph         = PH_HEADER;
        end
      end
      default: begin
        ph  = PH_IDLE;
        got = 1'b1;
        k   = KIND_ERR;
      end
    endcase
  endtask

  // advance the predicted block by one input item, queue the result it causes
  task automatic predict_flux(input desc_item_t it);
    bit          got;
    bit          known;
    logic [1:0]  k;
    logic [15:0] bits;
    logic [4:0]  cnt;
    logic [23:0] wk;
    logic        prev;
    flux_item_t  e;
    int          i;
    got  = 1'b0;
    k    = KIND_WORD;
    bits = '0;
    cnt  = '0;
    wk   = '0;
    if (it.command == CMD_START) begin
      cells_left = it.cell_budget;
      ph         = PH_HEADER;
      el_code    = '0;
      prm_left   = '0;
      prm_val    = '0;
      pay_left   = '0;
    end else if (ph != PH_IDLE) begin
      case (ph)
        PH_HEADER: begin
          el_code  = it.data_byte[4:0];
          prm_left = it.data_byte[7:5];
          prm_val  = '0;
          known    = (el_code == EL_END) || (el_code == EL_RAW) || (el_code == EL_DATA) ||
                     (el_code == EL_GAP) || (el_code == EL_WEAK);
          if (!known) begin
            ph  = PH_IDLE;
            got = 1'b1;
            k   = KIND_ERR;
          end else if (prm_left == 0) begin
            close_element(got, k, wk);
          end else begin
            ph = PH_PARAM;
          end
        end
        PH_PARAM: begin
          // big-endian, only the low 32 bits survive
          prm_val  = {prm_val[23:0], it.data_byte};
          prm_left = prm_left - 3'd1;
          if (prm_left == 0) begin
            close_element(got, k, wk);
          end
        end
        default: begin
          if (el_code == EL_RAW) begin
            bits    = {it.data_byte, 8'h00};
            cnt     = RAW_CELLS;
            mfm_ctx = it.data_byte[0];
          end else begin
            prev = mfm_ctx;
            for (i = 7; i >= 0; i--) begin
              bits = {bits[13:0], ~(prev | it.data_byte[i]), it.data_byte[i]};
              prev = it.data_byte[i];
            end
            mfm_ctx = prev;
            cnt     = MFM_CELLS;
          end
          got      = 1'b1;
          k        = KIND_WORD;
          pay_left = pay_left - 1;
          if (pay_left == 0) begin
            ph = PH_HEADER;
          end
        end
      endcase
      // stream ended while the block is still open
      if (it.final_byte && ph != PH_IDLE) begin
        ph  = PH_IDLE;
        got = 1'b1;
        k   = KIND_ERR;
      end
    end
    if (got) begin
      if (k != KIND_WORD) begin
        bits = '0;
        cnt  = '0;
      end
      if (k != KIND_WEAK) begin
        wk = '0;
      end
      e.kind       = k;
      e.cell_bits  = bits;
      e.cell_count = cnt;
      e.weak_cells = wk;
      flux_expected.push_back(e);
    end
  endtask

  // compare accepted results, then predict from accepted items
  always @(posedge clk) begin
    flux_item_t want;
    if (rst) begin
      ph         = PH_IDLE;
      el_code    = '0;
      prm_left   = '0;
      prm_val    = '0;
      pay_left   = '0;
      cells_left = '0;
      mfm_ctx    = 1'b0;
      n_flux     = 0;
      flux_expected.delete();
    end else begin
      if (flux_valid && !flux_stall) begin
        if (flux_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", flux_data));
        end else begin
          want = flux_expected.pop_front();
          if (flux_data.kind !== want.kind)
            report_mismatch($sformatf("kind %h want %h", flux_data.kind, want.kind));
          if (flux_data.cell_bits !== want.cell_bits)
            report_mismatch($sformatf("cell_bits %h want %h",
                                      flux_data.cell_bits, want.cell_bits));
          if (flux_data.cell_count !== want.cell_count)
            report_mismatch($sformatf("cell_count %0d want %0d",
                                      flux_data.cell_count, want.cell_count));
          if (flux_data.weak_cells !== want.weak_cells)
            report_mismatch($sformatf("weak_cells %h want %h",
                                      flux_data.weak_cells, want.weak_cells));
        end
        n_flux++;
      end
      if (desc_valid && !desc_stall) begin
        predict_flux(desc_data);
      end
    end
    pending = flux_expected.size();
  end

endmodule

### tb/block_data_stream_to_mfm_cells_tb.sv
// testbench top for the mfm cell converter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module block_data_stream_to_mfm_cells_tb;
  import mfmenc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 850;
  localparam logic [4:0] EL_UNUSED = 5'd4;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       desc_valid = 1'b0;
  logic       desc_stall;
  desc_item_t desc_data = '0;
  logic       flux_valid;
  logic       flux_stall = 1'b0;
  flux_item_t flux_data;

  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         flux_hold = 0;
  int         hold_draw;
  bit         calm = 1'b0;
  desc_item_t plan[$];

  block_data_stream_to_mfm_cells dut (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc_data  (desc_data),
    .flux_valid (flux_valid),
    .flux_stall (flux_stall),
    .flux_data  (flux_data)
  );

  flux_cell_checker chk (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc_data  (desc_data),
    .flux_valid (flux_valid),
    .flux_stall (flux_stall),
    .flux_data  (flux_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // receiver: after each accepted result, stall for a length drawn by draw_wait
  always @(posedge clk) begin
    if (rst) begin
      flux_stall <= 1'b0;
      flux_hold  <= 0;
    end else if (flux_valid && !flux_stall) begin
      hold_draw = draw_wait();
      flux_stall <= (hold_draw != 0);
      flux_hold  <= (hold_draw != 0) ? hold_draw - 1 : 0;
    end else if (flux_hold != 0) begin
      flux_hold  <= flux_hold - 1;
      flux_stall <= 1'b1;
    end else begin
      flux_stall <= 1'b0;
    end
  end

  task automatic add_start(input logic [23:0] budget);
    desc_item_t it;
    it.command     = CMD_START;
    it.cell_budget = budget;
    it.data_byte   = 8'($urandom);
    it.final_byte  = 1'($urandom);
    plan.push_back(it);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic fin);
    desc_item_t it;
    it.command     = CMD_BYTE;
    it.cell_budget = 24'($urandom);
    it.data_byte   = b;
    it.final_byte  = fin;
    plan.push_back(it);
  endtask

  // header, parameter bytes and payload of one element; returns the cells it uses
  task automatic add_element(input logic [4:0] code, input logic [31:0] param,
                             output int unsigned cells);
    int nbytes;
    int k;
    int i;
    nbytes = 0;
    for (i = 0; i < 4; i++) begin
      if (param[8*i +: 8] != 0) nbytes = i + 1;
    end
    // sometimes pad with leading bytes, beyond four they are shifted out
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(nbytes, 7) : nbytes;
    add_byte({k[2:0], code}, 1'b0);
    for (i = k - 1; i >= 0; i--) begin
      if (i < 4) add_byte(param[8*i +: 8], 1'b0);
      else add_byte(8'($urandom), 1'b0);
    end
    cells = 0;
    if (code == EL_RAW || code == EL_DATA || code == EL_GAP) begin
      cells = (code == EL_RAW) ? param * 8 : param * 16;
      for (i = 0; i < param; i++) add_byte(8'($urandom), 1'b0);
    end else if (code == EL_WEAK) begin
      cells = param * 16;
    end
  endtask

  // one block: mostly well formed, sometimes short, cut, corrupt or abandoned
  task automatic random_block();
    int unsigned total;
    int unsigned cells;
    int unsigned start_at;
    int unsigned n_el;
    int unsigned pick;
    int unsigned p;
    int unsigned j;
    int unsigned cut_at;
    int          delta;
    logic [4:0]  code;
    // stray bytes that may land while nothing is open
    if ($urandom_range(0, 9) == 0) begin
      add_byte(8'($urandom), 1'($urandom));
    end
    start_at = plan.size();
    add_start('0);
    total = 0;
    delta = 0;
    n_el  = $urandom_range(1, 6);
    for (j = 0; j < n_el; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) code = EL_RAW;
      else if (pick < 55) code = EL_DATA;
      else if (pick < 70) code = EL_GAP;
      else code = EL_WEAK;
      if (code == EL_WEAK && $urandom_range(0, 9) == 0)
        p = $urandom_range(0, (32'h00ff_ffff - total) / 16);
      else
        p = $urandom_range(0, 5);
      add_element(code, p, cells);
      total += cells;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      add_element(EL_END, ($urandom_range(0, 4) == 0) ? $urandom : 0, cells);
      plan[plan.size() - 1].final_byte = 1'($urandom);
      // budget that misses by 1 to 40 cells, either way
      if (pick >= 70) begin
        delta = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) delta = -delta;
      end
    end else if (pick < 88) begin
      add_element(EL_END, 0, cells);
      cut_at = $urandom_range(start_at + 1, plan.size() - 1);
      plan[cut_at].final_byte = 1'b1;
    end else if (pick < 94) begin
      code = ($urandom_range(0, 3) == 0) ? EL_UNUSED : 5'($urandom_range(6, 31));
      add_byte({3'($urandom), code}, 1'b0);
    end
    plan[start_at].cell_budget = 24'(total + delta);
  endtask

  task automatic send_desc(input desc_item_t it);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      desc_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    desc_valid <= 1'b1;
    desc_data  <= it;
    do @(posedge clk); while (desc_stall);
  endtask

  task automatic send_plan();
    while (plan.size() != 0) send_desc(plan.pop_front());
  endtask

  initial begin
    int sent;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // stray byte with nothing open, then a weak run that fills the whole budget
    add_byte(8'hff, 1'b1);
    add_start(24'hfffff0);
    add_byte({3'd3, EL_WEAK}, 1'b0);
    add_byte(8'h0f, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte({3'd0, EL_END}, 1'b1);
    // raw sets the mfm context, data follows, empty gap, end short of budget
    add_start(24'd32);
    add_byte({3'd1, EL_RAW}, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'ha5, 1'b0);
    add_byte({3'd1, EL_DATA}, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte({3'd0, EL_GAP}, 1'b0);
    add_byte({3'd0, EL_END}, 1'b0);
    // cell need that wraps 32 bits must still exceed the budget
    add_start(24'h000010);
    add_byte({3'd4, EL_DATA}, 1'b0);
    add_byte(8'h10, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b0);
    // unknown element code
    add_start(24'd0);
    add_byte({3'd0, EL_UNUSED}, 1'b0);
    // restart drops the open block, stream ends inside the payload
    add_start(24'hffffff);
    add_start(24'd16);
    add_byte({3'd1, EL_DATA}, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'hff, 1'b1);
    sent = plan.size();
    send_plan();

    // random blocks, with calm stretches where neither side idles
    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 7) == 0);
      random_block();
      sent += plan.size();
      send_plan();
    end
    desc_valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mfmenc_pkg.sv
rtl/mfmenc_front.sv
rtl/mfmenc_queue.sv
rtl/mfmenc_back.sv
rtl/block_data_stream_to_mfm_cells.sv
tb/flux_cell_checker.sv
tb/block_data_stream_to_mfm_cells_tb.sv
